### src/mcs_pkg.sv
// Package for the microcode control sequencer: item types, strobe bits, opcode and skip codes.
`default_nettype none
package mcs_pkg;

   localparam int StepWidth = 3;
   localparam int CwWidth   = 16;

   // control word strobe bit positions
   localparam int CwFi  = 0;
   localparam int CwJ   = 1;
   localparam int CwCo  = 2;
   localparam int CwCe  = 3;
   localparam int CwOi  = 4;
   localparam int CwBi  = 5;
   localparam int CwSu  = 6;
   localparam int CwEo  = 7;
   localparam int CwAo  = 8;
   localparam int CwAi  = 9;
   localparam int CwIi  = 10;
   localparam int CwIo  = 11;
   localparam int CwRo  = 12;
   localparam int CwRi  = 13;
   localparam int CwMi  = 14;
   localparam int CwHlt = 15;

   // opcodes
   localparam logic [3:0] OP_SKIP  = 4'd0;
   localparam logic [3:0] OP_LOAD  = 4'd1;
   localparam logic [3:0] OP_STORE = 4'd2;
   localparam logic [3:0] OP_ADD   = 4'd3;
   localparam logic [3:0] OP_SUB   = 4'd4;
   localparam logic [3:0] OP_ADC   = 4'd5;
   localparam logic [3:0] OP_SBC   = 4'd6;
   localparam logic [3:0] OP_OUT   = 4'd7;
   localparam logic [3:0] OP_JUMP  = 4'd8;

   // skip family codes (operand nibble)
   localparam logic [3:0] SK_NOP   = 4'd0;
   localparam logic [3:0] SK_HALT  = 4'd1;
   localparam logic [3:0] SK_OUTA  = 4'd2;
   localparam logic [3:0] SK_Z     = 4'd3;
   localparam logic [3:0] SK_NZ    = 4'd4;
   localparam logic [3:0] SK_C     = 4'd5;
   localparam logic [3:0] SK_NC    = 4'd6;
   localparam logic [3:0] SK_V     = 4'd7;
   localparam logic [3:0] SK_NV    = 4'd8;
   localparam logic [3:0] SK_N     = 4'd9;
   localparam logic [3:0] SK_NORZ  = 4'd10;
   localparam logic [3:0] SK_POS   = 4'd11;
   localparam logic [3:0] SK_NN    = 4'd12;

   // micro-steps
   localparam logic [StepWidth-1:0] STEP_FETCH0 = 3'd0;
   localparam logic [StepWidth-1:0] STEP_FETCH1 = 3'd1;
   localparam logic [StepWidth-1:0] STEP_EXEC0  = 3'd2;
   localparam logic [StepWidth-1:0] STEP_EXEC1  = 3'd3;
   localparam logic [StepWidth-1:0] STEP_EXEC2  = 3'd4;

   typedef struct packed {
      logic [3:0] opcode;
      logic [3:0] operand;
      logic       carry_flag;
      logic       zero_flag;
      logic       negative_flag;
      logic       overflow_flag;
   } req_type;

   typedef struct packed {
      logic [CwWidth-1:0]   control_word;
      logic                 carry_extend;
      logic [StepWidth-1:0] current_step;
      logic [StepWidth-1:0] next_step;
   } rsp_type;

endpackage
`default_nettype wire

### src/microcode_control_sequencer.sv
// Top level of the microcode control sequencer: step counter, decode and result skid buffer.
`default_nettype none
// One item per cycle while req_stall is low: each accepted item (opcode, operand, flags) is
// decoded against the micro-step counter in the same cycle and its control word is registered
// in a result register. The counter advances at each accepted item; a halt freezes it. A
// second result register takes an item while the first waits on rsp_stall; req_stall rises
// only when both are full.
module microcode_control_sequencer
   import mcs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic [StepWidth-1:0] step_ff;
   logic [StepWidth-1:0] step_in;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   rsp_type              out_ff;
   rsp_type              out_in;
   logic                 skid_valid_ff;
   logic                 skid_valid_in;
   rsp_type              skid_ff;
   rsp_type              skid_in;
   rsp_type              dec;
   logic                 accept;
   logic                 taken;

   mcs_decode u_decode (
      .step (step_ff),
      .req  (req_data),
      .rsp  (dec)
   );

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign taken     = out_valid_ff && !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      step_in       = accept ? dec.next_step : step_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (taken) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_in = dec;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff) begin
            out_in       = dec;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = dec;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= STEP_FETCH0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         step_ff       <= step_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // skid slot only ever fills behind a waiting result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds an item while result register is empty");

   // a halting control word never moves the step
   a_halt_freezes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.control_word[CwHlt]) |->
         (rsp_data.next_step == rsp_data.current_step))
      else $error("halt result with a moving step");

   // carry extend only on the ALU write-back step
   a_ext_on_alu: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.carry_extend) |->
         (rsp_data.control_word[CwEo] && rsp_data.control_word[CwFi]
          && rsp_data.next_step == STEP_FETCH0))
      else $error("carry extend outside the ALU step");

   // the counter follows the next step of the item just taken
   a_step_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> (step_ff == $past(dec.next_step)))
      else $error("step counter lost track of decoded next step");

endmodule
`default_nettype wire

### src/mcs_decode.sv
// Microcode decode: control word and next step from the current step and one item.
`default_nettype none
module mcs_decode
   import mcs_pkg::*;
(
   input  wire logic [StepWidth-1:0] step,
   input  wire req_type              req,
   output rsp_type                   rsp
);

   logic [CwWidth-1:0]   cw;
   logic                 ext;
   logic [StepWidth-1:0] nxt;
   logic                 halt;
   logic                 take;
   logic                 code_ok;

   // skip test evaluation
   always_comb begin
      take    = 1'b0;
      code_ok = 1'b1;
      case (req.operand)
         SK_Z:    take = req.zero_flag;
         SK_NZ:   take = !req.zero_flag;
         SK_C:    take = req.carry_flag;
         SK_NC:   take = !req.carry_flag;
         SK_V:    take = req.overflow_flag;
         SK_NV:   take = !req.overflow_flag;
         SK_N:    take = req.negative_flag;
         SK_NORZ: take = req.negative_flag || req.zero_flag;
         SK_POS:  take = !req.negative_flag && !req.zero_flag;
         SK_NN:   take = !req.negative_flag;
         default: code_ok = 1'b0;
      endcase
   end

   always_comb begin
      cw   = '0;
      ext  = 1'b0;
      nxt  = step + StepWidth'(1);
      halt = 1'b0;
      if (step == STEP_FETCH0) begin
         cw[CwCo] = 1'b1;
         cw[CwCe] = 1'b1;
         cw[CwMi] = 1'b1;
      end else if (step == STEP_FETCH1) begin
         cw[CwRo] = 1'b1;
         cw[CwIi] = 1'b1;
      end else begin
         case (req.opcode)
            OP_SKIP: begin
               if (step != STEP_EXEC0) begin
                  halt = 1'b1;
               end else if (req.operand == SK_NOP) begin
                  nxt = STEP_FETCH0;
               end else if (req.operand == SK_HALT) begin
                  halt = 1'b1;
               end else if (req.operand == SK_OUTA) begin
                  cw[CwAo] = 1'b1;
                  cw[CwOi] = 1'b1;
                  nxt      = STEP_FETCH0;
               end else if (!code_ok) begin
                  halt = 1'b1;
               end else begin
                  cw[CwCe] = take;
                  nxt      = STEP_FETCH0;
               end
            end
            OP_LOAD, OP_STORE, OP_OUT: begin
               if (step == STEP_EXEC0) begin
                  cw[CwIo] = 1'b1;
                  cw[CwMi] = 1'b1;
               end else if (step == STEP_EXEC1) begin
                  nxt = STEP_FETCH0;
                  if (req.opcode == OP_LOAD) begin
                     cw[CwRo] = 1'b1;
                     cw[CwAi] = 1'b1;
                  end else if (req.opcode == OP_STORE) begin
                     cw[CwAo] = 1'b1;
                     cw[CwRi] = 1'b1;
                  end else begin
                     cw[CwRo] = 1'b1;
                     cw[CwOi] = 1'b1;
                  end
               end else begin
                  halt = 1'b1;
               end
            end
            OP_ADD, OP_SUB, OP_ADC, OP_SBC: begin
               if (step == STEP_EXEC0) begin
                  cw[CwIo] = 1'b1;
                  cw[CwMi] = 1'b1;
               end else if (step == STEP_EXEC1) begin
                  cw[CwRo] = 1'b1;
                  cw[CwBi] = 1'b1;
               end else if (step == STEP_EXEC2) begin
                  cw[CwEo] = 1'b1;
                  cw[CwAi] = 1'b1;
                  cw[CwFi] = 1'b1;
                  cw[CwSu] = (req.opcode == OP_SUB) || (req.opcode == OP_SBC);
                  ext      = (req.opcode == OP_ADC) || (req.opcode == OP_SBC);
                  nxt      = STEP_FETCH0;
               end else begin
                  halt = 1'b1;
               end
            end
            OP_JUMP: begin
               if (step == STEP_EXEC0) begin
                  cw[CwIo] = 1'b1;
                  cw[CwJ]  = 1'b1;
                  nxt      = STEP_FETCH0;
               end else begin
                  halt = 1'b1;
               end
            end
            default: halt = 1'b1;
         endcase
      end
      // halt overrides everything and freezes the step
      if (halt) begin
         cw         = '0;
         cw[CwHlt]  = 1'b1;
         ext        = 1'b0;
         nxt        = step;
      end
   end

   assign rsp.control_word = cw;
   assign rsp.carry_extend = ext;
   assign rsp.current_step = step;
   assign rsp.next_step    = nxt;

endmodule
`default_nettype wire

### verif/tb_top.sv
// Testbench for the microcode control sequencer: directed and random instruction streams.
module tb_top;
   import mcs_pkg::*;

   localparam int ReportLimit = 10;

   // codes the package leaves unnamed, and flag sets in {C, Z, N, V} order
   localparam logic [3:0] OP_UNUSED_HI = 4'd15;
   localparam logic [3:0] SK_UNUSED_HI = 4'd15;
   localparam logic [3:0] FLAGS_NONE   = 4'b0000;
   localparam logic [3:0] FLAGS_ALL    = 4'b1111;
   localparam logic [3:0] FLAGS_Z      = 4'b0100;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic [StepWidth-1:0] machine_step = STEP_FETCH0;
   rsp_type              control_q[$];
   int                   mismatch_count = 0;
   int                   send_idle_pct  = 0;
   int                   recv_stall_pct = 0;
   logic [3:0]           prog_op  = OP_SKIP;
   logic [3:0]           prog_arg = SK_NOP;

   microcode_control_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Control word, carry select and step transition for one item at the given step.
   function automatic rsp_type decode_step(input logic [StepWidth-1:0] step, input req_type r);
      rsp_type o;
      logic    halt;
      logic    is_test;
      logic    take;
      o              = '0;
      o.current_step = step;
      o.next_step    = step + 3'd1;
      halt           = 1'b0;
      is_test        = 1'b0;
      take           = 1'b0;
      if (step == STEP_FETCH0) begin
         o.control_word[CwCo] = 1'b1;
         o.control_word[CwCe] = 1'b1;
         o.control_word[CwMi] = 1'b1;
      end else if (step == STEP_FETCH1) begin
         o.control_word[CwRo] = 1'b1;
         o.control_word[CwIi] = 1'b1;
      end else begin
         case (r.opcode)
            OP_SKIP: begin
               if (step != STEP_EXEC0) begin
                  halt = 1'b1;
               end else begin
                  o.next_step = STEP_FETCH0;
                  is_test     = 1'b1;
                  case (r.operand)
                     SK_NOP:  is_test = 1'b0;
                     SK_HALT: halt = 1'b1;
                     SK_OUTA: begin
                        is_test              = 1'b0;
                        o.control_word[CwAo] = 1'b1;
                        o.control_word[CwOi] = 1'b1;
                     end
                     SK_Z:    take = r.zero_flag;
                     SK_NZ:   take = !r.zero_flag;
                     SK_C:    take = r.carry_flag;
                     SK_NC:   take = !r.carry_flag;
                     SK_V:    take = r.overflow_flag;
                     SK_NV:   take = !r.overflow_flag;
                     SK_N:    take = r.negative_flag;
                     SK_NORZ: take = r.negative_flag || r.zero_flag;
                     SK_POS:  take = !r.negative_flag && !r.zero_flag;
                     SK_NN:   take = !r.negative_flag;
                     default: halt = 1'b1;
                  endcase
                  o.control_word[CwCe] = is_test && take;
               end
            end
            OP_LOAD, OP_STORE, OP_OUT: begin
               if (step == STEP_EXEC0) begin
                  o.control_word[CwIo] = 1'b1;
                  o.control_word[CwMi] = 1'b1;
               end else if (step == STEP_EXEC1) begin
                  o.next_step = STEP_FETCH0;
                  if (r.opcode == OP_LOAD) begin
                     o.control_word[CwRo] = 1'b1;
                     o.control_word[CwAi] = 1'b1;
                  end else if (r.opcode == OP_STORE) begin
                     o.control_word[CwAo] = 1'b1;
                     o.control_word[CwRi] = 1'b1;
                  end else begin
                     o.control_word[CwRo] = 1'b1;
                     o.control_word[CwOi] = 1'b1;
                  end
               end else begin
                  halt = 1'b1;
               end
            end
            OP_ADD, OP_SUB, OP_ADC, OP_SBC: begin
               if (step == STEP_EXEC0) begin
                  o.control_word[CwIo] = 1'b1;
                  o.control_word[CwMi] = 1'b1;
               end else if (step == STEP_EXEC1) begin
                  o.control_word[CwRo] = 1'b1;
                  o.control_word[CwBi] = 1'b1;
               end else if (step == STEP_EXEC2) begin
                  o.next_step          = STEP_FETCH0;
                  o.control_word[CwEo] = 1'b1;
                  o.control_word[CwAi] = 1'b1;
                  o.control_word[CwFi] = 1'b1;
                  o.control_word[CwSu] = (r.opcode == OP_SUB) || (r.opcode == OP_SBC);
                  o.carry_extend       = (r.opcode == OP_ADC) || (r.opcode == OP_SBC);
               end else begin
                  halt = 1'b1;
               end
            end
            OP_JUMP: begin
               if (step == STEP_EXEC0) begin
                  o.next_step          = STEP_FETCH0;
                  o.control_word[CwIo] = 1'b1;
                  o.control_word[CwJ]  = 1'b1;
               end else begin
                  halt = 1'b1;
               end
            end
            default: halt = 1'b1;
         endcase
      end
      if (halt) begin
         o.control_word         = '0;
         o.control_word[CwHlt]  = 1'b1;
         o.carry_extend         = 1'b0;
         o.next_step            = step;
      end
      return o;
   endfunction

   // Drives one item, waits for it to be taken, then queues the control word it should produce.
   task automatic send_item(input req_type item);
      rsp_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = decode_step(machine_step, item);
      control_q.push_back(want);
      machine_step = want.next_step;
   endtask

   task automatic pick_instruction(input logic allow_unused);
      if (allow_unused && $urandom_range(99) < 12) prog_op = 4'($urandom_range(15, 9));
      else prog_op = 4'($urandom_range(8));
      prog_arg = 4'($urandom_range(15));
   endtask

   // Foreign opcodes during fetch, then a full subtract with borrow.
   task automatic test_fetch_and_sbc;
      send_item({OP_UNUSED_HI, SK_UNUSED_HI, FLAGS_ALL});
      send_item({OP_JUMP, SK_NOP, FLAGS_NONE});
      send_item({OP_SBC, SK_UNUSED_HI, FLAGS_ALL});
      send_item({OP_SBC, SK_NOP, FLAGS_NONE});
      send_item({OP_SBC, SK_N, FLAGS_Z});
   endtask

   task automatic test_store;
      send_item({OP_STORE, SK_NOP, FLAGS_NONE});
      send_item({OP_STORE, SK_NOP, FLAGS_NONE});
      send_item({OP_STORE, SK_NOP, FLAGS_ALL});
      send_item({OP_STORE, SK_NOP, FLAGS_ALL});
   endtask

   // Halt freezes the counter; a taken skip releases it.
   task automatic test_halt_code;
      send_item({OP_SKIP, SK_HALT, FLAGS_NONE});
      send_item({OP_SKIP, SK_HALT, FLAGS_NONE});
      send_item({OP_SKIP, SK_HALT, FLAGS_NONE});
      send_item({OP_SKIP, SK_HALT, FLAGS_ALL});
      send_item({OP_SKIP, SK_Z, FLAGS_Z});
   endtask

   task automatic test_unused_skip_code;
      send_item({OP_SKIP, SK_UNUSED_HI, FLAGS_NONE});
      send_item({OP_SKIP, SK_UNUSED_HI, FLAGS_NONE});
      send_item({OP_SKIP, SK_UNUSED_HI, FLAGS_ALL});
      send_item({OP_JUMP, SK_UNUSED_HI, FLAGS_ALL});
   endtask

   task automatic test_unused_opcode;
      send_item({OP_UNUSED_HI, SK_NOP, FLAGS_NONE});
      send_item({OP_UNUSED_HI, SK_NOP, FLAGS_NONE});
      send_item({OP_UNUSED_HI, SK_NOP, FLAGS_NONE});
      send_item({OP_LOAD, SK_NOP, FLAGS_NONE});
      send_item({OP_LOAD, SK_NOP, FLAGS_NONE});
   endtask

   // Jump has no second execute step, so it halts there until add resumes.
   task automatic test_overlong_step;
      send_item({OP_ADD, SK_NOP, FLAGS_NONE});
      send_item({OP_ADD, SK_NOP, FLAGS_NONE});
      send_item({OP_ADD, SK_NOP, FLAGS_NONE});
      send_item({OP_JUMP, SK_NOP, FLAGS_NONE});
      send_item({OP_ADD, SK_NOP, FLAGS_ALL});
      send_item({OP_ADD, SK_NOP, FLAGS_ALL});
   endtask

   // Mostly whole instructions with random flags, some halts left frozen a while, some noise.
   task automatic test_random_programs(input int count, input int idle_pct, input int stall_pct);
      req_type                   item;
      rsp_type                   probe;
      logic [3:0]                flags;
      logic [31:0]               rnd;
      logic [$bits(req_type)-1:0] raw;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) begin
         if (machine_step == STEP_FETCH0) pick_instruction(1'b1);
         flags = 4'($urandom_range(15));
         item  = {prog_op, prog_arg, flags};
         probe = decode_step(machine_step, item);
         if (probe.control_word[CwHlt] && $urandom_range(1) == 1) begin
            do begin
               pick_instruction(1'b0);
               item  = {prog_op, prog_arg, flags};
               probe = decode_step(machine_step, item);
            end while (probe.control_word[CwHlt]);
         end
         if ($urandom_range(99) < 10) begin
            rnd  = $urandom();
            raw  = rnd[$bits(req_type)-1:0];
            item = raw;
         end
         send_item(item);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (control_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit)
               $display("unexpected result item: %h", rsp_data);
         end else begin
            want = control_q.pop_front();
            if (rsp_data.control_word !== want.control_word ||
                rsp_data.carry_extend !== want.carry_extend ||
                rsp_data.current_step !== want.current_step ||
                rsp_data.next_step !== want.next_step) begin
               mismatch_count++;
               if (mismatch_count <= ReportLimit)
                  $display("mismatch: cw %h/%h ext %b/%b step %0d/%0d next %0d/%0d (exp/act)",
                           want.control_word, rsp_data.control_word,
                           want.carry_extend, rsp_data.carry_extend,
                           want.current_step, rsp_data.current_step,
                           want.next_step, rsp_data.next_step);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_fetch_and_sbc();
      test_store();
      test_halt_code();
      test_unused_skip_code();
      test_unused_opcode();
      test_overlong_step();
      test_random_programs(412, 0, 0);
      test_random_programs(412, 80, 0);
      test_random_programs(413, 0, 80);
      test_random_programs(413, 7, 7);
      req_valid <= 1'b0;
      while (control_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### sim.f
src/mcs_pkg.sv
src/mcs_decode.sv
src/microcode_control_sequencer.sv
verif/tb_top.sv
